### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro expands to one labelled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the expression in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("same-cycle implication check failed");

// The condition implies the expression in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle implication check failed");

`endif

### hw/rtl/c2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c2p_pkg;

   // Field widths of the transactions.
   localparam int COORD_WIDTH    = 16;
   localparam int RADIUS_WIDTH   = 16;
   localparam int ANGLE_WIDTH    = 15;
   localparam int LOCATION_WIDTH = 2;
   localparam int QUADRANT_WIDTH = 3;

   // CORDIC and square root sizing.
   localparam int CORDIC_STAGES = 16;
   localparam int SCALE_SHIFT   = 16;
   localparam int CX_WIDTH      = COORD_WIDTH + SCALE_SHIFT + 3;
   localparam int Z_WIDTH       = 33;
   localparam int SQ_WIDTH      = 2 * COORD_WIDTH;
   localparam int ROOT_BITS     = COORD_WIDTH;
   localparam int PIPE_STEPS    = (CORDIC_STAGES > ROOT_BITS) ? CORDIC_STAGES : ROOT_BITS;

   // Binary angle: 2^BAM_WIDTH is a full turn.
   localparam int BAM_WIDTH  = 32;
   localparam int A_WIDTH    = BAM_WIDTH + 1;
   localparam int PROD_WIDTH = A_WIDTH + ANGLE_WIDTH;
   localparam int ROUND_WIDTH = PROD_WIDTH - BAM_WIDTH;

   // Angle constants in 1/64 degree.
   localparam int DEG_UNITS  = 64;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_FULL  = ANGLE_WIDTH'(360 * DEG_UNITS);
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_ZERO  = '0;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_90    = ANGLE_WIDTH'(90 * DEG_UNITS);
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_180   = ANGLE_WIDTH'(180 * DEG_UNITS);
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_270   = ANGLE_WIDTH'(270 * DEG_UNITS);

   // Pipeline layout: input, square, sum, loop steps, map, multiply, output.
   localparam int LOOP_BASE  = 3;
   localparam int POST_BASE  = LOOP_BASE + PIPE_STEPS;
   localparam int POST_DEPTH = 3;
   localparam int PIPE_DEPTH = POST_BASE + POST_DEPTH;

   // Location codes.
   localparam logic [LOCATION_WIDTH-1:0] LOC_ORIGIN   = 2'd0;
   localparam logic [LOCATION_WIDTH-1:0] LOC_X_AXIS   = 2'd1;
   localparam logic [LOCATION_WIDTH-1:0] LOC_Y_AXIS   = 2'd2;
   localparam logic [LOCATION_WIDTH-1:0] LOC_QUADRANT = 2'd3;

   // Quadrant codes.
   localparam logic [QUADRANT_WIDTH-1:0] QUAD_NONE = 3'd0;
   localparam logic [QUADRANT_WIDTH-1:0] QUAD_1    = 3'd1;
   localparam logic [QUADRANT_WIDTH-1:0] QUAD_2    = 3'd2;
   localparam logic [QUADRANT_WIDTH-1:0] QUAD_3    = 3'd3;
   localparam logic [QUADRANT_WIDTH-1:0] QUAD_4    = 3'd4;

   typedef logic signed [COORD_WIDTH-1:0]    coord_type;
   typedef logic [COORD_WIDTH-1:0]           mag_type;
   typedef logic [RADIUS_WIDTH-1:0]          radius_type;
   typedef logic [ANGLE_WIDTH-1:0]           angle_type;
   typedef logic [LOCATION_WIDTH-1:0]        location_type;
   typedef logic [QUADRANT_WIDTH-1:0]        quadrant_type;

   // Classification that travels alongside the arithmetic.
   typedef struct packed {
      location_type location;
      quadrant_type quadrant;
      angle_type    axis_angle;
   } meta_type;

   // State of one CORDIC and square root step.
   typedef struct packed {
      logic signed [CX_WIDTH-1:0] cx;
      logic signed [CX_WIDTH-1:0] cy;
      logic signed [Z_WIDTH-1:0]  z;
      logic [SQ_WIDTH-1:0]        rem;
      logic [SQ_WIDTH-1:0]        root;
      meta_type                   meta;
   } loop_type;

   // One finished result.
   typedef struct packed {
      radius_type   radius;
      angle_type    angle;
      location_type location;
      quadrant_type quadrant;
   } result_type;

   // atan(2^-idx) as a binary angle, rounded to nearest.
   function automatic logic [BAM_WIDTH-1:0] atan_entry(input int unsigned idx);
      logic [BAM_WIDTH-1:0] val;
      unique case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         24: val = 32'd41;
         25: val = 32'd20;
         26: val = 32'd10;
         27: val = 32'd5;
         28: val = 32'd3;
         29: val = 32'd1;
         30: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/c2p_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Point channel.
interface c2p_req_if import c2p_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type x_coord;
   coord_type y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

// Polar result channel.
interface c2p_rsp_if import c2p_pkg::*; ();
   logic         valid;
   logic         ready;
   radius_type   radius;
   angle_type    angle;
   location_type location;
   quadrant_type quadrant;

   modport source (output valid, output radius, output angle, output location,
                   output quadrant, input ready);
   modport sink (input valid, input radius, input angle, input location,
                 input quadrant, output ready);
endinterface

`default_nettype wire

### hw/rtl/c2p_flow.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module c2p_flow import c2p_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [PIPE_DEPTH-1:0] load
);

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] valid_prev;
   logic [PIPE_DEPTH-1:0] holes;
   logic                  in_fire;
   logic                  out_fire;

   // A stage loads when the sink is ready or any stage at or after it is empty.
   assign holes = ~valid_ff;
   always_comb begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
         load[k] = out_ready || (|(holes >> k));
      end
   end

   // Valid bits move with their data; a stage that does not load keeps its bit.
   assign valid_prev = {valid_ff[PIPE_DEPTH-2:0], in_valid};
   assign valid_in   = (load & valid_prev) | (~load & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Handshake outputs are held off while reset is applied.
   assign in_ready  = load[0] && !reset;
   assign out_valid = valid_ff[PIPE_DEPTH-1] && !reset;
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = out_valid && out_ready;

   `ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, valid_ff == '0)
   `ASSERT_IMPLIES(a_hole_gives_ready, clock, reset, !(&valid_ff), in_ready)
   `ASSERT_NEXT(a_occupancy, clock, reset, 1'b1, $countones(valid_ff) == $past($countones(valid_ff)) + $past(in_fire) - $past(out_fire))

endmodule

`default_nettype wire

### hw/rtl/c2p_core.sv
`timescale 1ns / 1ps
`default_nettype none

module c2p_core import c2p_pkg::*; (
   input  logic                  clock,
   input  logic [PIPE_STEPS-1:0] load,
   input  loop_type              entry,
   output loop_type              last
);

   loop_type step_ff [PIPE_STEPS];

   for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_step
      localparam bit DO_ROT   = (k < CORDIC_STAGES);
      localparam bit DO_ROOT  = (k < ROOT_BITS);
      localparam int SQ_SHIFT = DO_ROOT ? 2 * (ROOT_BITS - 1 - k) : 0;
      localparam logic [SQ_WIDTH:0] BIT_B = (SQ_WIDTH + 1)'(1) << SQ_SHIFT;
      localparam logic signed [Z_WIDTH-1:0] ATAN_K =
         signed'(Z_WIDTH'(atan_entry(k)));

      loop_type                   step_cur;
      loop_type                   step_in;
      logic signed [CX_WIDTH-1:0] dx;
      logic signed [CX_WIDTH-1:0] dy;
      logic [SQ_WIDTH:0]          trial;
      logic [SQ_WIDTH:0]          rem_ext;

      if (k == 0) begin : g_first
         assign step_cur = entry;
      end else begin : g_rest
         assign step_cur = step_ff[k-1];
      end

      assign dx      = step_cur.cy >>> k;
      assign dy      = step_cur.cx >>> k;
      assign trial   = {1'b0, step_cur.root} + BIT_B;
      assign rem_ext = {1'b0, step_cur.rem};

      // One vectoring rotation towards the x axis and one square root digit.
      always_comb begin
         step_in = step_cur;
         if (DO_ROT) begin
            if (!step_cur.cy[CX_WIDTH-1]) begin
               step_in.cx = step_cur.cx + dx;
               step_in.cy = step_cur.cy - dy;
               step_in.z  = step_cur.z + ATAN_K;
            end else begin
               step_in.cx = step_cur.cx - dx;
               step_in.cy = step_cur.cy + dy;
               step_in.z  = step_cur.z - ATAN_K;
            end
         end
         if (DO_ROOT) begin
            if (rem_ext >= trial) begin
               step_in.rem  = SQ_WIDTH'(rem_ext - trial);
               step_in.root = (step_cur.root >> 1) + SQ_WIDTH'(BIT_B);
            end else begin
               step_in.root = step_cur.root >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (load[k]) begin
            step_ff[k] <= step_in;
         end
      end
   end

   assign last = step_ff[PIPE_STEPS-1];

endmodule

`default_nettype wire

### hw/rtl/c2p_post.sv
`timescale 1ns / 1ps
`default_nettype none

module c2p_post import c2p_pkg::*; (
   input  logic                  clock,
   input  logic [POST_DEPTH-1:0] load,
   input  loop_type              loop_out,
   output result_type            result
);

   localparam logic signed [Z_WIDTH-1:0] Z_QUARTER = Z_WIDTH'(1) << (BAM_WIDTH - 2);
   localparam logic [A_WIDTH-1:0] A_HALF = A_WIDTH'(1) << (BAM_WIDTH - 1);
   localparam logic [A_WIDTH-1:0] A_TURN = A_WIDTH'(1) << BAM_WIDTH;
   localparam logic [PROD_WIDTH-1:0] FULL_MULT = PROD_WIDTH'(ANGLE_FULL);
   localparam logic [ROUND_WIDTH-1:0] FULL_ROUND = ROUND_WIDTH'(ANGLE_FULL);

   typedef struct packed {
      logic [A_WIDTH-1:0] circle;
      radius_type         radius;
      meta_type           meta;
   } map_type;

   typedef struct packed {
      logic [PROD_WIDTH-1:0] prod;
      radius_type            radius;
      meta_type              meta;
   } mult_type;

   map_type    map_ff;
   map_type    map_in;
   mult_type   mult_ff;
   mult_type   mult_in;
   result_type out_ff;
   result_type out_in;

   logic [A_WIDTH-1:0]     zc;
   logic [ROUND_WIDTH-1:0] rounded;
   angle_type              wrapped;

   // Clamp the first quadrant angle and fold it onto the full circle.
   always_comb begin
      if (loop_out.z[Z_WIDTH-1]) begin
         zc = '0;
      end else if (loop_out.z > Z_QUARTER) begin
         zc = A_WIDTH'(Z_QUARTER);
      end else begin
         zc = A_WIDTH'(loop_out.z);
      end
      map_in.radius = radius_type'(loop_out.root[RADIUS_WIDTH-1:0]);
      map_in.meta   = loop_out.meta;
      unique case (loop_out.meta.quadrant)
         QUAD_2:  map_in.circle = A_HALF - zc;
         QUAD_3:  map_in.circle = A_HALF + zc;
         QUAD_4:  map_in.circle = A_TURN - zc;
         default: map_in.circle = zc;
      endcase
   end

   // Scale the binary angle to 1/64 degree units.
   always_comb begin
      mult_in.prod   = PROD_WIDTH'(map_ff.circle) * FULL_MULT;
      mult_in.radius = map_ff.radius;
      mult_in.meta   = map_ff.meta;
   end

   // Round half up, wrap a full turn to zero and pick the axis answer off the quadrants.
   assign rounded = mult_ff.prod[PROD_WIDTH-1:BAM_WIDTH]
                    + ROUND_WIDTH'(mult_ff.prod[BAM_WIDTH-1]);
   always_comb begin
      if (rounded >= FULL_ROUND) begin
         wrapped = angle_type'(rounded - FULL_ROUND);
      end else begin
         wrapped = angle_type'(rounded);
      end
      out_in.radius   = mult_ff.radius;
      out_in.location = mult_ff.meta.location;
      out_in.quadrant = mult_ff.meta.quadrant;
      if (mult_ff.meta.location == LOC_QUADRANT) begin
         out_in.angle = wrapped;
      end else begin
         out_in.angle = mult_ff.meta.axis_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         map_ff <= map_in;
      end
      if (load[1]) begin
         mult_ff <= mult_in;
      end
      if (load[2]) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

`default_nettype wire

### hw/rtl/cartesian_to_polar.sv
// Cartesian to polar converter.
// A point enters as a transaction on req_bus (x_coord, y_coord, signed) and one
// result leaves as a transaction on rsp_bus: radius (integer part of the
// distance), angle in 1/64 degree counterclockwise from the positive x axis,
// location (origin, x axis, y axis or inside a quadrant) and quadrant number.
// Both channels use valid and ready; a transaction completes on a clock edge
// where both are high.
// The datapath is a 22-stage pipeline: input register, squaring, sum, one stage
// per CORDIC rotation and square root digit (16), quadrant mapping, angle
// scaling and an output register. One point can be accepted every cycle
// while req_bus.ready is high. When the receiver holds ready low the results
// stay put and the pipeline closes its empty stages; req_bus.ready drops only
// when every stage is full.
// Synchronous reset empties the pipeline; both ready and valid are low while
// reset is applied.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_polar import c2p_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   c2p_req_if.sink    req_bus,
   c2p_rsp_if.source  rsp_bus
);

   typedef struct packed {
      mag_type  mag_x;
      mag_type  mag_y;
      meta_type meta;
   } front_type;

   typedef struct packed {
      logic [SQ_WIDTH-1:0] sq_x;
      logic [SQ_WIDTH-1:0] sq_y;
      mag_type             mag_x;
      mag_type             mag_y;
      meta_type            meta;
   } square_type;

   typedef struct packed {
      logic [SQ_WIDTH-1:0] sum;
      mag_type             mag_x;
      mag_type             mag_y;
      meta_type            meta;
   } sum_type;

   logic [PIPE_DEPTH-1:0] load;
   logic                  in_ready;
   logic                  out_valid;
   front_type             front_ff;
   front_type             front_in;
   square_type            square_ff;
   square_type            square_in;
   sum_type               sum_ff;
   sum_type               sum_in;
   loop_type              entry;
   loop_type              loop_out;
   result_type            result;
   mag_type               x_raw;
   mag_type               y_raw;
   logic                  x_zero;
   logic                  y_zero;
   logic                  x_neg;
   logic                  y_neg;

   // Valid bits and stage enables.
   c2p_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (rsp_bus.ready),
      .load      (load)
   );

   assign req_bus.ready = in_ready;

   // Magnitudes and classification of the incoming point.
   assign x_raw  = mag_type'(req_bus.x_coord);
   assign y_raw  = mag_type'(req_bus.y_coord);
   assign x_neg  = x_raw[COORD_WIDTH-1];
   assign y_neg  = y_raw[COORD_WIDTH-1];
   assign x_zero = (x_raw == '0);
   assign y_zero = (y_raw == '0);

   always_comb begin
      front_in.mag_x = x_neg ? mag_type'(~x_raw + 1'b1) : x_raw;
      front_in.mag_y = y_neg ? mag_type'(~y_raw + 1'b1) : y_raw;
      front_in.meta.quadrant = QUAD_NONE;
      priority if (x_zero && y_zero) begin
         front_in.meta.location   = LOC_ORIGIN;
         front_in.meta.axis_angle = ANGLE_ZERO;
      end else if (y_zero) begin
         front_in.meta.location   = LOC_X_AXIS;
         front_in.meta.axis_angle = x_neg ? ANGLE_180 : ANGLE_ZERO;
      end else if (x_zero) begin
         front_in.meta.location   = LOC_Y_AXIS;
         front_in.meta.axis_angle = y_neg ? ANGLE_270 : ANGLE_90;
      end else begin
         front_in.meta.location   = LOC_QUADRANT;
         front_in.meta.axis_angle = ANGLE_ZERO;
         if (!x_neg && !y_neg) begin
            front_in.meta.quadrant = QUAD_1;
         end else if (x_neg && !y_neg) begin
            front_in.meta.quadrant = QUAD_2;
         end else if (x_neg) begin
            front_in.meta.quadrant = QUAD_3;
         end else begin
            front_in.meta.quadrant = QUAD_4;
         end
      end
   end

   // Squares of the magnitudes.
   always_comb begin
      square_in.sq_x  = SQ_WIDTH'(front_ff.mag_x) * SQ_WIDTH'(front_ff.mag_x);
      square_in.sq_y  = SQ_WIDTH'(front_ff.mag_y) * SQ_WIDTH'(front_ff.mag_y);
      square_in.mag_x = front_ff.mag_x;
      square_in.mag_y = front_ff.mag_y;
      square_in.meta  = front_ff.meta;
   end

   // Sum of squares feeding the square root.
   always_comb begin
      sum_in.sum   = square_ff.sq_x + square_ff.sq_y;
      sum_in.mag_x = square_ff.mag_x;
      sum_in.mag_y = square_ff.mag_y;
      sum_in.meta  = square_ff.meta;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         front_ff <= front_in;
      end
      if (load[1]) begin
         square_ff <= square_in;
      end
      if (load[2]) begin
         sum_ff <= sum_in;
      end
   end

   // The CORDIC works on the magnitudes scaled up by the fraction bits.
   always_comb begin
      entry.cx   = signed'({{(CX_WIDTH - COORD_WIDTH - SCALE_SHIFT){1'b0}},
                            sum_ff.mag_x, {SCALE_SHIFT{1'b0}}});
      entry.cy   = signed'({{(CX_WIDTH - COORD_WIDTH - SCALE_SHIFT){1'b0}},
                            sum_ff.mag_y, {SCALE_SHIFT{1'b0}}});
      entry.z    = '0;
      entry.rem  = sum_ff.sum;
      entry.root = '0;
      entry.meta = sum_ff.meta;
   end

   c2p_core u_core (
      .clock (clock),
      .load  (load[LOOP_BASE +: PIPE_STEPS]),
      .entry (entry),
      .last  (loop_out)
   );

   c2p_post u_post (
      .clock    (clock),
      .load     (load[POST_BASE +: POST_DEPTH]),
      .loop_out (loop_out),
      .result   (result)
   );

   assign rsp_bus.valid    = out_valid;
   assign rsp_bus.radius   = result.radius;
   assign rsp_bus.angle    = result.angle;
   assign rsp_bus.location = result.location;
   assign rsp_bus.quadrant = result.quadrant;

endmodule

`default_nettype wire

### sim/cartesian_to_polar_tb.sv
`timescale 1ns / 1ps

module cartesian_to_polar_tb;
   import c2p_pkg::*;

   localparam int unsigned RANDOM_POINTS = 1250;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned HOLD_POINTS   = 80;
   localparam int unsigned LIMIT_CYCLES  = 500000;

   // Kinds of random point.
   typedef enum int {
      PT_ANY,
      PT_SMALL,
      PT_AXIS,
      PT_EXTREME,
      PT_DIAGONAL
   } point_kind_type;

   // Receiver behaviour between long hold-offs.
   typedef enum int {
      RX_ALWAYS,
      RX_HALF,
      RX_MOSTLY,
      RX_SPARSE
   } rx_mode_type;

   // One accepted point and the polar form it should produce.
   typedef struct {
      coord_type  x;
      coord_type  y;
      result_type want;
   } pending_point_type;

   // Predicts the polar form of each accepted point and checks results in order.
   class polar_scoreboard;
      pending_point_type   outstanding[$];
      int unsigned         mismatches;
      longint unsigned     atan_bam[32];

      function new();
         mismatches = 0;
         // atan(2^-i) as a binary angle where 2^32 is a full turn.
         atan_bam = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
            81, 41, 20, 10, 5, 3, 1, 1, 0
         };
      endfunction

      function int unsigned pending();
         return outstanding.size();
      endfunction

      // Polar form of one point.
      function result_type polar_of(coord_type x, coord_type y);
         longint          ax;
         longint          ay;
         longint          sum_sq;
         longint          root;
         longint          cx;
         longint          cy;
         longint          dx;
         longint          dy;
         longint          zacc;
         longint unsigned circ;
         longint unsigned full;
         longint unsigned ang;
         result_type      r;
         ax = (x < 0) ? -longint'(x) : longint'(x);
         ay = (y < 0) ? -longint'(y) : longint'(y);
         sum_sq = ax * ax + ay * ay;

         // Integer square root, corrected after the floating estimate.
         root = longint'($sqrt(real'(sum_sq)));
         while (root * root > sum_sq)
            root--;
         while ((root + 1) * (root + 1) <= sum_sq)
            root++;
         r.radius = radius_type'(root);
         r.quadrant = QUAD_NONE;

         if (x == 0 && y == 0) begin
            r.location = LOC_ORIGIN;
            r.angle = ANGLE_ZERO;
         end else if (y == 0) begin
            r.location = LOC_X_AXIS;
            r.angle = (x > 0) ? ANGLE_ZERO : ANGLE_180;
         end else if (x == 0) begin
            r.location = LOC_Y_AXIS;
            r.angle = (y > 0) ? ANGLE_90 : ANGLE_270;
         end else begin
            // Vectoring rotations on the magnitudes, scaled up by 2^16.
            cx = ax <<< SCALE_SHIFT;
            cy = ay <<< SCALE_SHIFT;
            zacc = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
               dx = cy >>> i;
               dy = cx >>> i;
               if (cy >= 0) begin
                  cx = cx + dx;
                  cy = cy - dy;
                  zacc = zacc + longint'(atan_bam[i]);
               end else begin
                  cx = cx - dx;
                  cy = cy + dy;
                  zacc = zacc - longint'(atan_bam[i]);
               end
            end
            if (zacc < 0)
               zacc = 0;
            if (zacc > (64'sd1 <<< 30))
               zacc = 64'sd1 <<< 30;

            // Fold the first-quadrant angle out to the whole circle.
            r.location = LOC_QUADRANT;
            if (x > 0 && y > 0) begin
               r.quadrant = QUAD_1;
               circ = longint'(zacc);
            end else if (x < 0 && y > 0) begin
               r.quadrant = QUAD_2;
               circ = (64'd1 << 31) - longint'(zacc);
            end else if (x < 0) begin
               r.quadrant = QUAD_3;
               circ = (64'd1 << 31) + longint'(zacc);
            end else begin
               r.quadrant = QUAD_4;
               circ = (64'd1 << 32) - longint'(zacc);
            end

            // Scale to 1/64 degree, rounding half up; a full turn wraps to zero.
            full = longint'(ANGLE_FULL);
            ang = (circ * full + (64'd1 << 31)) >> 32;
            if (ang >= full)
               ang = ang - full;
            r.angle = angle_type'(ang);
         end
         return r;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      // Records an accepted point with its predicted result.
      function void note_point(coord_type x, coord_type y);
         pending_point_type p;
         p.x = x;
         p.y = y;
         p.want = polar_of(x, y);
         outstanding.push_back(p);
      endfunction

      // Compares one accepted result with the oldest prediction.
      task check_result(radius_type radius, angle_type angle, location_type location,
                        quadrant_type quadrant);
         pending_point_type p;
         if (outstanding.size() == 0) begin
            report_mismatch($sformatf("result (%0d, %0d) with no point outstanding",
                                      radius, angle));
         end else begin
            p = outstanding.pop_front();
            if (radius !== p.want.radius)
               report_mismatch($sformatf("(%0d,%0d) radius %0d, expected %0d",
                                         p.x, p.y, radius, p.want.radius));
            if (angle !== p.want.angle)
               report_mismatch($sformatf("(%0d,%0d) angle %0d, expected %0d",
                                         p.x, p.y, angle, p.want.angle));
            if (location !== p.want.location)
               report_mismatch($sformatf("(%0d,%0d) location %0d, expected %0d",
                                         p.x, p.y, location, p.want.location));
            if (quadrant !== p.want.quadrant)
               report_mismatch($sformatf("(%0d,%0d) quadrant %0d, expected %0d",
                                         p.x, p.y, quadrant, p.want.quadrant));
         end
      endtask
   endclass

   logic            clock = 1'b0;
   logic            reset;
   int unsigned     hold_requests;
   int unsigned     cycle_count;
   polar_scoreboard board;

   c2p_req_if req_if ();
   c2p_rsp_if rsp_if ();

   cartesian_to_polar u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit in case the block stops making progress.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result monitor: checks every completed result transaction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.check_result(rsp_if.radius, rsp_if.angle, rsp_if.location, rsp_if.quadrant);
   end

   // Receiver: a changing stall pattern, with a long hold-off on request.
   initial begin : receiver
      int unsigned holds_seen;
      int unsigned stall_left;
      int unsigned mode_left;
      rx_mode_type mode;
      holds_seen = 0;
      stall_left = 0;
      mode_left = 0;
      mode = RX_ALWAYS;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(RX_ALWAYS, RX_SPARSE));
               mode_left = $urandom_range(5, 80);
            end
            mode_left--;
            case (mode)
               RX_ALWAYS: rsp_if.ready <= 1'b1;
               RX_HALF:   rsp_if.ready <= $urandom_range(0, 1) == 0;
               RX_MOSTLY: rsp_if.ready <= $urandom_range(0, 3) != 0;
               default:   rsp_if.ready <= $urandom_range(0, 5) == 0;
            endcase
         end
      end
   end

   // Offers one point and waits for its transaction to complete.
   task automatic send_point(input coord_type x, input coord_type y);
      req_if.valid   <= 1'b1;
      req_if.x_coord <= x;
      req_if.y_coord <= y;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      board.note_point(x, y);
   endtask

   // Stops offering and waits until every predicted result has arrived.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   function automatic coord_type extreme_value();
      case ($urandom_range(0, 6))
         0:       return coord_type'(-32768);
         1:       return coord_type'(-32767);
         2:       return coord_type'(32767);
         3:       return coord_type'(32766);
         4:       return coord_type'(-1);
         5:       return coord_type'(1);
         default: return coord_type'(0);
      endcase
   endfunction

   // Picks a random point, weighted towards small points, axes, extremes and diagonals.
   task automatic pick_point(output coord_type x, output coord_type y);
      point_kind_type kind;
      kind = point_kind_type'($urandom_range(0, 9) < 5 ? PT_ANY
                                                       : $urandom_range(PT_SMALL, PT_DIAGONAL));
      case (kind)
         PT_SMALL: begin
            x = coord_type'($signed($urandom_range(0, 16)) - 8);
            y = coord_type'($signed($urandom_range(0, 16)) - 8);
         end
         PT_AXIS: begin
            x = coord_type'($urandom);
            y = 0;
            if ($urandom_range(0, 1) == 0) begin
               y = x;
               x = 0;
            end
         end
         PT_EXTREME: begin
            x = extreme_value();
            y = ($urandom_range(0, 1) == 0) ? extreme_value() : coord_type'($urandom);
         end
         PT_DIAGONAL: begin
            x = coord_type'($urandom);
            y = ($urandom_range(0, 1) == 0) ? x : -x;
            if ($urandom_range(0, 3) == 0)
               y = y + coord_type'($signed($urandom_range(0, 2)) - 1);
         end
         default: begin
            x = coord_type'($urandom);
            y = coord_type'($urandom);
         end
      endcase
   endtask

   // Stimulus: directed points, a long receiver hold-off, then random bursts.
   initial begin : stimulus
      coord_type   px;
      coord_type   py;
      int unsigned random_sent;
      int unsigned burst;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.x_coord <= '0;
      req_if.y_coord <= '0;
      hold_requests  <= 0;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Origin, both axes in both directions, corners, unit diagonals, near-axis points and two general points.
      send_point(0, 0);
      send_point(32767, 0);
      send_point(-32768, 0);
      send_point(0, 32767);
      send_point(0, -32768);
      send_point(1, 0);
      send_point(-1, 0);
      send_point(0, 1);
      send_point(0, -1);
      send_point(32767, 32767);
      send_point(-32768, 32767);
      send_point(-32768, -32768);
      send_point(32767, -32768);
      send_point(1, 1);
      send_point(-1, 1);
      send_point(-1, -1);
      send_point(1, -1);
      send_point(32767, 1);
      send_point(1, 32767);
      send_point(-32768, -1);
      send_point(-1, -32768);
      send_point(3, -4);
      send_point(-12345, 23456);
      drain_results();

      // Receiver holds off while points keep coming, so the pipeline fills.
      hold_requests <= hold_requests + 1;
      repeat (HOLD_POINTS) begin
         pick_point(px, py);
         send_point(px, py);
      end
      drain_results();

      // Random bursts with random gaps between them.
      random_sent = 0;
      while (random_sent < RANDOM_POINTS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            pick_point(px, py);
            send_point(px, py);
            random_sent++;
         end
         case ($urandom_range(0, 5))
            0, 1: ;
            2: begin
               req_if.valid <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end
            3: begin
               req_if.valid <= 1'b0;
               repeat ($urandom_range(4, 25)) @(posedge clock);
            end
            4: begin
               if ($urandom_range(0, 7) == 0)
                  drain_results();
            end
            default: begin
               req_if.valid <= 1'b0;
               @(posedge clock);
            end
         endcase
      end

      // Let the pipeline empty and make sure nothing extra comes out.
      drain_results();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (board.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/c2p_pkg.sv
hw/rtl/c2p_if.sv
hw/rtl/c2p_flow.sv
hw/rtl/c2p_core.sv
hw/rtl/c2p_post.sv
hw/rtl/cartesian_to_polar.sv
sim/cartesian_to_polar_tb.sv
